>>> rtl/jtok_pkg.sv
// shared types, codes and sizes for the json tokenizer
package jtok_pkg;

    localparam int MAX_TOKENS = 256;
    localparam int MAX_TEXT   = 65536;
    localparam int IDX_W      = $clog2(MAX_TOKENS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int OFS_W      = $clog2(MAX_TEXT) + 1;
    localparam int START_W    = 16;
    localparam int END_W      = 18;
    localparam int CHILD_W    = 8;

    typedef enum logic [1:0] {
        ACT_TEXT   = 2'd0,
        ACT_FINISH = 2'd1,
        ACT_READ   = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_OBJ  = 2'd0,
        KIND_ARR  = 2'd1,
        KIND_STR  = 2'd2,
        KIND_PRIM = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_PARTIAL = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        MODE_MAIN = 3'd0,
        MODE_STR  = 3'd1,
        MODE_ESC  = 3'd2,
        MODE_HEX  = 3'd3,
        MODE_PRIM = 3'd4
    } mode_t;

    typedef struct packed {
        kind_t                kind;
        logic [START_W-1:0]   start;
        logic [END_W-1:0]     finish;
        logic [CHILD_W-1:0]   children;
    } entry_t;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_PRINT_LO = 8'd32;
    localparam logic [7:0] CH_PRINT_HI = 8'd127;

endpackage

>>> rtl/jtok_cmd_if.sv
// command channel: action, text byte and table index
interface jtok_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] data_byte;
    logic [7:0] token_index;

    modport source (output valid, output action, output data_byte, output token_index,
                    input ready);
    modport sink (input valid, input action, input data_byte, input token_index,
                  output ready);
endinterface

>>> rtl/jtok_rsp_if.sv
// response channel: status, count and one table entry
interface jtok_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [8:0]  token_count;
    logic [1:0]  token_kind;
    logic [15:0] token_start;
    logic [17:0] token_end;
    logic [7:0]  token_children;

    modport source (output valid, output status, output token_count, output token_kind,
                    output token_start, output token_end, output token_children,
                    input ready);
    modport sink (input valid, input status, input token_count, input token_kind,
                  input token_start, input token_end, input token_children,
                  output ready);
endinterface

>>> rtl/jtok_table.sv
// token table ram, one write port and one registered read port
module jtok_table (
    input  logic                      clk,
    input  logic                      we,
    input  logic [jtok_pkg::IDX_W-1:0] waddr,
    input  jtok_pkg::entry_t          wdata,
    input  logic [jtok_pkg::IDX_W-1:0] raddr,
    output jtok_pkg::entry_t          rdata
);

    jtok_pkg::entry_t mem [jtok_pkg::MAX_TOKENS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/json_tokenizer.sv
// json tokenizer top level: byte sequencer around the token table
//
// cmd carries one action per transfer: a text byte, finish, read entry or
// clear. Every command gives exactly one transfer on rsp with the status,
// the entry count and, for a read, the entry fields (zero otherwise).
// The block handles one command at a time; cmd.ready is high only while
// idle, and it drops after a transfer until the response has been taken.
// A clear and an ignored byte go straight to the response; a read passes
// S_READ_RD and S_READ_OUT, a text byte S_ENC_RD and S_DECIDE. Closing
// brackets, commas after a value and finish walk back over the table
// through its single read port, a read and a check state per entry.
// strict_mode is written through cfg_write/cfg_data; the user is to do so
// only while no command is in flight, the block does not enforce it. While
// rsp.ready is low the response is held and no new command is taken. Reset
// returns the tokenizer to an empty table with strict mode off; table
// contents are left as they are and only entries below the count are ever read.
module json_tokenizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_data,
    jtok_cmd_if.sink    cmd,
    jtok_rsp_if.source  rsp
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENC_RD,
        S_DECIDE,
        S_MAIN,
        S_BUMP,
        S_FIN,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_READ_RD,
        S_READ_OUT,
        S_RESP
    } state_t;

    typedef enum logic [1:0] {
        SC_CLOSE,
        SC_ENCL,
        SC_COMMA,
        SC_OPEN
    } scan_t;

    localparam int IW = jtok_pkg::IDX_W;
    localparam int CW = jtok_pkg::CNT_W;
    localparam int OW = jtok_pkg::OFS_W;
    localparam int EW = jtok_pkg::END_W;
    localparam int SW = jtok_pkg::START_W;
    localparam int HW = jtok_pkg::CHILD_W;

    state_t              state_reg, state_next;
    scan_t               scan_op_reg, scan_op_next;
    jtok_pkg::mode_t     mode_reg, mode_next;
    jtok_pkg::action_t   act_reg, act_next;
    logic [OW-1:0]       offset_reg, offset_next;
    logic [OW-1:0]       pos_reg, pos_next;
    logic [OW-1:0]       begin_reg, begin_next;
    logic [CW-1:0]       nf_reg, nf_next;
    logic [IW+1:0]       enc_reg, enc_next;
    logic [IW+1:0]       encs_reg, encs_next;
    logic [2:0]          hex_reg, hex_next;
    logic [1:0]          sticky_reg, sticky_next;
    logic                stopped_reg, stopped_next;
    logic                strict_reg, strict_next;
    logic                part_reg, part_next;
    logic                then_main_reg, then_main_next;
    logic [7:0]          byte_reg, byte_next;
    logic [IW-1:0]       addr_reg, addr_next;
    logic [CW-1:0]       scan_reg, scan_next;
    jtok_pkg::entry_t    ent_reg, ent_next;
    jtok_pkg::kind_t     okind_reg, okind_next;
    logic [SW-1:0]       ostart_reg, ostart_next;
    logic [EW-1:0]       oend_reg, oend_next;
    logic [HW-1:0]       ochild_reg, ochild_next;

    logic                we;
    logic [IW-1:0]       waddr;
    jtok_pkg::entry_t    wdata;
    jtok_pkg::entry_t    mem_q;

    logic                full;
    logic                enc_ok;
    logic                is_ws;
    logic                is_hex;
    logic                prim_ok;
    logic                printable;
    logic                last;
    logic                open_q;
    jtok_pkg::kind_t     want;

    jtok_table u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (addr_reg),
        .rdata (mem_q)
    );

    assign full      = (nf_reg == CW'(jtok_pkg::MAX_TOKENS));
    assign enc_ok    = !encs_reg[IW+1];
    assign is_ws     = (byte_reg == jtok_pkg::CH_TAB) || (byte_reg == jtok_pkg::CH_CR)
                       || (byte_reg == jtok_pkg::CH_LF) || (byte_reg == jtok_pkg::CH_SPACE);
    assign is_hex    = (byte_reg inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    assign prim_ok   = (byte_reg inside {[8'h30:8'h39]}) || (byte_reg == jtok_pkg::CH_MINUS)
                       || (byte_reg == jtok_pkg::CH_LOW_T) || (byte_reg == jtok_pkg::CH_LOW_F)
                       || (byte_reg == jtok_pkg::CH_LOW_N);
    assign printable = (byte_reg >= jtok_pkg::CH_PRINT_LO) && (byte_reg < jtok_pkg::CH_PRINT_HI);
    assign last      = (scan_reg == CW'(1));
    assign open_q    = (mem_q.finish == '1);
    assign want      = (byte_reg == jtok_pkg::CH_RBRACE) ? jtok_pkg::KIND_OBJ
                                                         : jtok_pkg::KIND_ARR;

    always_comb
    begin
        state_next     = state_reg;
        scan_op_next   = scan_op_reg;
        mode_next      = mode_reg;
        act_next       = act_reg;
        offset_next    = offset_reg;
        pos_next       = pos_reg;
        begin_next     = begin_reg;
        nf_next        = nf_reg;
        enc_next       = enc_reg;
        encs_next      = encs_reg;
        hex_next       = hex_reg;
        sticky_next    = sticky_reg;
        stopped_next   = stopped_reg;
        strict_next    = cfg_write ? cfg_data : strict_reg;
        part_next      = part_reg;
        then_main_next = then_main_reg;
        byte_next      = byte_reg;
        addr_next      = addr_reg;
        scan_next      = scan_reg;
        ent_next       = ent_reg;
        okind_next     = okind_reg;
        ostart_next    = ostart_reg;
        oend_next      = oend_reg;
        ochild_next    = ochild_reg;
        we             = 1'b0;
        waddr          = nf_reg[IW-1:0];
        wdata          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    act_next    = jtok_pkg::action_t'(cmd.action);
                    byte_next   = cmd.data_byte;
                    encs_next   = enc_reg;
                    addr_next   = enc_reg[IW-1:0];
                    part_next   = 1'b0;
                    okind_next  = jtok_pkg::KIND_OBJ;
                    ostart_next = '0;
                    oend_next   = '0;
                    ochild_next = '0;
                    state_next  = S_RESP;
                    case (jtok_pkg::action_t'(cmd.action))
                        jtok_pkg::ACT_TEXT:
                        begin
                            if (sticky_reg == jtok_pkg::ST_OK && !stopped_reg)
                            begin
                                if (mode_reg == jtok_pkg::MODE_ESC
                                    && cmd.data_byte == jtok_pkg::CH_NUL)
                                begin
                                    sticky_next = jtok_pkg::ST_INVALID;
                                end
                                else if (cmd.data_byte == jtok_pkg::CH_NUL)
                                begin
                                    stopped_next = 1'b1;
                                end
                                else if (offset_reg < OW'(jtok_pkg::MAX_TEXT))
                                begin
                                    pos_next    = offset_reg;
                                    offset_next = offset_reg + OW'(1);
                                    state_next  = S_ENC_RD;
                                end
                            end
                        end
                        jtok_pkg::ACT_FINISH:
                        begin
                            state_next = S_FIN;
                            if (sticky_reg == jtok_pkg::ST_OK
                                && mode_reg == jtok_pkg::MODE_PRIM && !strict_reg)
                            begin
                                if (full)
                                begin
                                    sticky_next = jtok_pkg::ST_FULL;
                                end
                                else
                                begin
                                    pos_next   = offset_reg;
                                    state_next = S_ENC_RD;
                                end
                            end
                        end
                        jtok_pkg::ACT_READ:
                        begin
                            if ({1'b0, cmd.token_index} < nf_reg)
                            begin
                                addr_next  = cmd.token_index[IW-1:0];
                                state_next = S_READ_RD;
                            end
                        end
                        default:
                        begin
                            mode_next    = jtok_pkg::MODE_MAIN;
                            offset_next  = '0;
                            nf_next      = '0;
                            enc_next     = '1;
                            begin_next   = '0;
                            hex_next     = '0;
                            sticky_next  = jtok_pkg::ST_OK;
                            stopped_next = 1'b0;
                        end
                    endcase
                end
            end

            S_ENC_RD:
            begin
                state_next = S_DECIDE;
            end

            S_DECIDE:
            begin
                ent_next       = mem_q;
                state_next     = S_RESP;
                then_main_next = 1'b0;
                wdata.kind     = jtok_pkg::KIND_PRIM;
                wdata.start    = begin_reg[SW-1:0];
                wdata.finish   = EW'(pos_reg);
                wdata.children = '0;
                if (act_reg == jtok_pkg::ACT_FINISH)
                begin
                    we         = 1'b1;
                    nf_next    = nf_reg + CW'(1);
                    mode_next  = jtok_pkg::MODE_MAIN;
                    state_next = S_BUMP;
                end
                else
                begin
                    case (mode_reg)
                        jtok_pkg::MODE_STR:
                        begin
                            if (byte_reg == jtok_pkg::CH_QUOTE)
                            begin
                                if (full)
                                begin
                                    sticky_next = jtok_pkg::ST_FULL;
                                end
                                else
                                begin
                                    wdata.kind  = jtok_pkg::KIND_STR;
                                    wdata.start = SW'(begin_reg + OW'(1));
                                    we          = 1'b1;
                                    nf_next     = nf_reg + CW'(1);
                                    mode_next   = jtok_pkg::MODE_MAIN;
                                    state_next  = S_BUMP;
                                end
                            end
                            else if (byte_reg == jtok_pkg::CH_BSLASH)
                            begin
                                mode_next = jtok_pkg::MODE_ESC;
                            end
                        end
                        jtok_pkg::MODE_ESC:
                        begin
                            if (byte_reg == jtok_pkg::CH_QUOTE || byte_reg == jtok_pkg::CH_SLASH
                                || byte_reg == jtok_pkg::CH_BSLASH
                                || byte_reg == jtok_pkg::CH_LOW_B
                                || byte_reg == jtok_pkg::CH_LOW_F
                                || byte_reg == jtok_pkg::CH_LOW_R
                                || byte_reg == jtok_pkg::CH_LOW_N
                                || byte_reg == jtok_pkg::CH_LOW_T)
                            begin
                                mode_next = jtok_pkg::MODE_STR;
                            end
                            else if (byte_reg == jtok_pkg::CH_LOW_U)
                            begin
                                mode_next = jtok_pkg::MODE_HEX;
                                hex_next  = '0;
                            end
                            else
                            begin
                                sticky_next = jtok_pkg::ST_INVALID;
                            end
                        end
                        jtok_pkg::MODE_HEX:
                        begin
                            if (!is_hex)
                            begin
                                sticky_next = jtok_pkg::ST_INVALID;
                            end
                            else if (hex_reg == 3'd3)
                            begin
                                hex_next  = '0;
                                mode_next = jtok_pkg::MODE_STR;
                            end
                            else
                            begin
                                hex_next = hex_reg + 3'd1;
                            end
                        end
                        jtok_pkg::MODE_PRIM:
                        begin
                            if ((byte_reg == jtok_pkg::CH_COLON && !strict_reg) || is_ws
                                || byte_reg == jtok_pkg::CH_COMMA
                                || byte_reg == jtok_pkg::CH_RBRACK
                                || byte_reg == jtok_pkg::CH_RBRACE)
                            begin
                                if (full)
                                begin
                                    sticky_next = jtok_pkg::ST_FULL;
                                end
                                else
                                begin
                                    we             = 1'b1;
                                    nf_next        = nf_reg + CW'(1);
                                    mode_next      = jtok_pkg::MODE_MAIN;
                                    then_main_next = 1'b1;
                                    state_next     = S_BUMP;
                                end
                            end
                            else if (!printable)
                            begin
                                sticky_next = jtok_pkg::ST_INVALID;
                            end
                        end
                        default:
                        begin
                            state_next = S_MAIN;
                        end
                    endcase
                end
            end

            S_BUMP:
            begin
                if (enc_ok && ent_reg.children != '1)
                begin
                    we             = 1'b1;
                    waddr          = encs_reg[IW-1:0];
                    wdata          = ent_reg;
                    wdata.children = ent_reg.children + HW'(1);
                end
                if (then_main_reg)
                begin
                    state_next = S_MAIN;
                end
                else if (act_reg == jtok_pkg::ACT_FINISH)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end

            S_MAIN:
            begin
                state_next     = S_RESP;
                then_main_next = 1'b0;
                if (byte_reg == jtok_pkg::CH_LBRACE || byte_reg == jtok_pkg::CH_LBRACK)
                begin
                    if (full)
                    begin
                        sticky_next = jtok_pkg::ST_FULL;
                    end
                    else if (strict_reg && enc_ok && ent_reg.kind == jtok_pkg::KIND_OBJ)
                    begin
                        sticky_next = jtok_pkg::ST_INVALID;
                    end
                    else
                    begin
                        we             = 1'b1;
                        wdata.kind     = (byte_reg == jtok_pkg::CH_LBRACE) ? jtok_pkg::KIND_OBJ
                                                                           : jtok_pkg::KIND_ARR;
                        wdata.start    = pos_reg[SW-1:0];
                        wdata.finish   = '1;
                        wdata.children = '0;
                        nf_next        = nf_reg + CW'(1);
                        enc_next       = {2'b00, nf_reg[IW-1:0]};
                        state_next     = S_BUMP;
                    end
                end
                else if (byte_reg == jtok_pkg::CH_RBRACE || byte_reg == jtok_pkg::CH_RBRACK)
                begin
                    if (nf_reg == '0)
                    begin
                        sticky_next = jtok_pkg::ST_INVALID;
                    end
                    else
                    begin
                        scan_op_next = SC_CLOSE;
                        scan_next    = nf_reg;
                        addr_next    = IW'(nf_reg - CW'(1));
                        state_next   = S_SCAN_RD;
                    end
                end
                else if (byte_reg == jtok_pkg::CH_QUOTE)
                begin
                    mode_next  = jtok_pkg::MODE_STR;
                    begin_next = pos_reg;
                end
                else if (is_ws)
                begin
                    state_next = S_RESP;
                end
                else if (byte_reg == jtok_pkg::CH_COLON)
                begin
                    enc_next = {1'b0, nf_reg} - (IW+2)'(1);
                end
                else if (byte_reg == jtok_pkg::CH_COMMA)
                begin
                    if (enc_ok && (ent_reg.kind == jtok_pkg::KIND_STR
                                   || ent_reg.kind == jtok_pkg::KIND_PRIM))
                    begin
                        scan_op_next = SC_COMMA;
                        scan_next    = nf_reg;
                        addr_next    = IW'(nf_reg - CW'(1));
                        state_next   = S_SCAN_RD;
                    end
                end
                else
                begin
                    if (strict_reg && (!prim_ok || (enc_ok
                        && (ent_reg.kind == jtok_pkg::KIND_OBJ
                            || (ent_reg.kind == jtok_pkg::KIND_STR && ent_reg.children != '0)))))
                    begin
                        sticky_next = jtok_pkg::ST_INVALID;
                    end
                    else if (!printable)
                    begin
                        sticky_next = jtok_pkg::ST_INVALID;
                    end
                    else
                    begin
                        mode_next  = jtok_pkg::MODE_PRIM;
                        begin_next = pos_reg;
                    end
                end
            end

            S_FIN:
            begin
                state_next = S_RESP;
                if (sticky_reg == jtok_pkg::ST_OK)
                begin
                    if (mode_reg != jtok_pkg::MODE_MAIN)
                    begin
                        part_next = 1'b1;
                    end
                    else if (nf_reg != '0)
                    begin
                        scan_op_next = SC_OPEN;
                        scan_next    = nf_reg;
                        addr_next    = IW'(nf_reg - CW'(1));
                        state_next   = S_SCAN_RD;
                    end
                end
            end

            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end

            S_SCAN_CHK:
            begin
                scan_next  = scan_reg - CW'(1);
                addr_next  = IW'(scan_reg - CW'(2));
                state_next = last ? S_RESP : S_SCAN_RD;
                case (scan_op_reg)
                    SC_CLOSE:
                    begin
                        if (open_q)
                        begin
                            if (mem_q.kind != want)
                            begin
                                sticky_next = jtok_pkg::ST_INVALID;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                we           = 1'b1;
                                waddr        = addr_reg;
                                wdata        = mem_q;
                                wdata.finish = EW'(pos_reg) + EW'(1);
                                enc_next     = '1;
                                scan_op_next = SC_ENCL;
                            end
                        end
                        else if (last)
                        begin
                            sticky_next = jtok_pkg::ST_INVALID;
                        end
                    end
                    SC_ENCL:
                    begin
                        if (open_q)
                        begin
                            enc_next   = {2'b00, addr_reg};
                            state_next = S_RESP;
                        end
                    end
                    SC_COMMA:
                    begin
                        if (open_q && (mem_q.kind == jtok_pkg::KIND_ARR
                                       || mem_q.kind == jtok_pkg::KIND_OBJ))
                        begin
                            enc_next   = {2'b00, addr_reg};
                            state_next = S_RESP;
                        end
                    end
                    default:
                    begin
                        if (open_q)
                        begin
                            part_next  = 1'b1;
                            state_next = S_RESP;
                        end
                    end
                endcase
            end

            S_READ_RD:
            begin
                state_next = S_READ_OUT;
            end

            S_READ_OUT:
            begin
                okind_next  = mem_q.kind;
                ostart_next = mem_q.start;
                oend_next   = mem_q.finish;
                ochild_next = mem_q.children;
                state_next  = S_RESP;
            end

            S_RESP:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_op_reg   <= SC_CLOSE;
            mode_reg      <= jtok_pkg::MODE_MAIN;
            act_reg       <= jtok_pkg::ACT_TEXT;
            offset_reg    <= '0;
            pos_reg       <= '0;
            begin_reg     <= '0;
            nf_reg        <= '0;
            enc_reg       <= '1;
            encs_reg      <= '1;
            hex_reg       <= '0;
            sticky_reg    <= jtok_pkg::ST_OK;
            stopped_reg   <= 1'b0;
            strict_reg    <= 1'b0;
            part_reg      <= 1'b0;
            then_main_reg <= 1'b0;
            byte_reg      <= '0;
            addr_reg      <= '0;
            scan_reg      <= '0;
            ent_reg       <= '0;
            okind_reg     <= jtok_pkg::KIND_OBJ;
            ostart_reg    <= '0;
            oend_reg      <= '0;
            ochild_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_op_reg   <= scan_op_next;
            mode_reg      <= mode_next;
            act_reg       <= act_next;
            offset_reg    <= offset_next;
            pos_reg       <= pos_next;
            begin_reg     <= begin_next;
            nf_reg        <= nf_next;
            enc_reg       <= enc_next;
            encs_reg      <= encs_next;
            hex_reg       <= hex_next;
            sticky_reg    <= sticky_next;
            stopped_reg   <= stopped_next;
            strict_reg    <= strict_next;
            part_reg      <= part_next;
            then_main_reg <= then_main_next;
            byte_reg      <= byte_next;
            addr_reg      <= addr_next;
            scan_reg      <= scan_next;
            ent_reg       <= ent_next;
            okind_reg     <= okind_next;
            ostart_reg    <= ostart_next;
            oend_reg      <= oend_next;
            ochild_reg    <= ochild_next;
        end
    end

    assign cmd.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = (state_reg == S_RESP);
    assign rsp.status         = part_reg ? jtok_pkg::ST_PARTIAL : sticky_reg;
    assign rsp.token_count    = nf_reg;
    assign rsp.token_kind     = okind_reg;
    assign rsp.token_start    = ostart_reg;
    assign rsp.token_end      = oend_reg;
    assign rsp.token_children = ochild_reg;

endmodule

>>> rtl/jtok_checker.sv
// port-level checks for the json tokenizer, bound to the top level
module jtok_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [8:0] out_count
);

    // one command in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("command taken while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("ready while response pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> in_ready && !out_valid)
        else $error("no return to idle after response transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_count))
        else $error("stalled response changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_count <= 9'd256)
        else $error("entry count out of range");

endmodule

bind json_tokenizer jtok_checker u_jtok_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_count (rsp.token_count)
);

>>> tb/sv/tb_json_tokenizer.sv
// self-checking testbench for the json tokenizer with a built-in token table predictor
`timescale 1ns / 100ps

typedef struct {
    jtok_pkg::status_t status;
    logic [8:0]        count;
    logic [1:0]        kind;
    logic [15:0]       start;
    logic [17:0]       finish;
    logic [7:0]        children;
} tok_rsp_t;

class tok_scoreboard;
    bit                 strict;
    jtok_pkg::mode_t    mode;
    int                 ofs;
    int                 used;
    int                 parent;
    int                 item_start;
    int                 hex_cnt;
    jtok_pkg::status_t  err;
    bit                 stopped;
    jtok_pkg::kind_t    kinds[jtok_pkg::MAX_TOKENS];
    int                 starts[jtok_pkg::MAX_TOKENS];
    int                 ends[jtok_pkg::MAX_TOKENS];
    int                 kids[jtok_pkg::MAX_TOKENS];
    tok_rsp_t           pending_q[$];
    int                 errors;

    function new();
        strict = 0;
        errors = 0;
        restart();
    endfunction

    function void restart();
        mode = jtok_pkg::MODE_MAIN;
        ofs = 0;
        used = 0;
        parent = -1;
        item_start = 0;
        hex_cnt = 0;
        err = jtok_pkg::ST_OK;
        stopped = 0;
    endfunction

    function void add_child();
        if (parent >= 0 && kids[parent] < 255)
            kids[parent]++;
    endfunction

    function void put(int idx, jtok_pkg::kind_t k, int b, int e);
        kinds[idx] = k;
        starts[idx] = b;
        ends[idx] = e;
        kids[idx] = 0;
    endfunction

    function jtok_pkg::status_t close_prim(int e);
        if (used >= jtok_pkg::MAX_TOKENS)
            return jtok_pkg::ST_FULL;
        put(used, jtok_pkg::KIND_PRIM, item_start, e);
        used++;
        add_child();
        mode = jtok_pkg::MODE_MAIN;
        return jtok_pkg::ST_OK;
    endfunction

    function bit is_ws(logic [7:0] c);
        return c == jtok_pkg::CH_TAB || c == jtok_pkg::CH_CR || c == jtok_pkg::CH_LF
               || c == jtok_pkg::CH_SPACE;
    endfunction

    function jtok_pkg::status_t main_byte(logic [7:0] c, int pos);
        int              i;
        jtok_pkg::kind_t want;
        if (c == jtok_pkg::CH_LBRACE || c == jtok_pkg::CH_LBRACK)
        begin
            if (used >= jtok_pkg::MAX_TOKENS)
                return jtok_pkg::ST_FULL;
            if (parent >= 0 && strict && kinds[parent] == jtok_pkg::KIND_OBJ)
                return jtok_pkg::ST_INVALID;
            used++;
            add_child();
            put(used - 1, (c == jtok_pkg::CH_LBRACE) ? jtok_pkg::KIND_OBJ : jtok_pkg::KIND_ARR,
                pos, -1);
            parent = used - 1;
            return jtok_pkg::ST_OK;
        end
        if (c == jtok_pkg::CH_RBRACE || c == jtok_pkg::CH_RBRACK)
        begin
            want = (c == jtok_pkg::CH_RBRACE) ? jtok_pkg::KIND_OBJ : jtok_pkg::KIND_ARR;
            for (i = used - 1; i >= 0; i--)
                if (ends[i] == -1)
                    break;
            if (i < 0 || kinds[i] != want)
                return jtok_pkg::ST_INVALID;
            ends[i] = pos + 1;
            parent = -1;
            for (; i >= 0; i--)
                if (ends[i] == -1)
                begin
                    parent = i;
                    break;
                end
            return jtok_pkg::ST_OK;
        end
        if (c == jtok_pkg::CH_QUOTE)
        begin
            mode = jtok_pkg::MODE_STR;
            item_start = pos;
            return jtok_pkg::ST_OK;
        end
        if (is_ws(c))
            return jtok_pkg::ST_OK;
        if (c == jtok_pkg::CH_COLON)
        begin
            parent = used - 1;
            return jtok_pkg::ST_OK;
        end
        if (c == jtok_pkg::CH_COMMA)
        begin
            if (parent >= 0 && kinds[parent] != jtok_pkg::KIND_ARR
                && kinds[parent] != jtok_pkg::KIND_OBJ)
                for (i = used - 1; i >= 0; i--)
                    if ((kinds[i] == jtok_pkg::KIND_ARR || kinds[i] == jtok_pkg::KIND_OBJ)
                        && ends[i] == -1)
                    begin
                        parent = i;
                        break;
                    end
            return jtok_pkg::ST_OK;
        end
        if (strict)
        begin
            if (!(c == jtok_pkg::CH_MINUS || (c >= 48 && c <= 57) || c == jtok_pkg::CH_LOW_T
                  || c == jtok_pkg::CH_LOW_F || c == jtok_pkg::CH_LOW_N))
                return jtok_pkg::ST_INVALID;
            if (parent >= 0 && (kinds[parent] == jtok_pkg::KIND_OBJ
                || (kinds[parent] == jtok_pkg::KIND_STR && kids[parent] != 0)))
                return jtok_pkg::ST_INVALID;
        end
        if (c < jtok_pkg::CH_PRINT_LO || c >= jtok_pkg::CH_PRINT_HI)
            return jtok_pkg::ST_INVALID;
        mode = jtok_pkg::MODE_PRIM;
        item_start = pos;
        return jtok_pkg::ST_OK;
    endfunction

    function jtok_pkg::status_t text_byte(logic [7:0] c, int pos);
        jtok_pkg::status_t r;
        case (mode)
            jtok_pkg::MODE_STR:
            begin
                if (c == jtok_pkg::CH_QUOTE)
                begin
                    if (used >= jtok_pkg::MAX_TOKENS)
                        return jtok_pkg::ST_FULL;
                    put(used, jtok_pkg::KIND_STR, item_start + 1, pos);
                    used++;
                    add_child();
                    mode = jtok_pkg::MODE_MAIN;
                end
                else if (c == jtok_pkg::CH_BSLASH)
                    mode = jtok_pkg::MODE_ESC;
                return jtok_pkg::ST_OK;
            end
            jtok_pkg::MODE_ESC:
            begin
                if (c == jtok_pkg::CH_QUOTE || c == jtok_pkg::CH_SLASH
                    || c == jtok_pkg::CH_BSLASH || c == jtok_pkg::CH_LOW_B
                    || c == jtok_pkg::CH_LOW_F || c == jtok_pkg::CH_LOW_R
                    || c == jtok_pkg::CH_LOW_N || c == jtok_pkg::CH_LOW_T)
                begin
                    mode = jtok_pkg::MODE_STR;
                    return jtok_pkg::ST_OK;
                end
                if (c == jtok_pkg::CH_LOW_U)
                begin
                    mode = jtok_pkg::MODE_HEX;
                    hex_cnt = 0;
                    return jtok_pkg::ST_OK;
                end
                return jtok_pkg::ST_INVALID;
            end
            jtok_pkg::MODE_HEX:
            begin
                if (!((c >= 48 && c <= 57) || (c >= 65 && c <= 70) || (c >= 97 && c <= 102)))
                    return jtok_pkg::ST_INVALID;
                hex_cnt++;
                if (hex_cnt >= 4)
                begin
                    hex_cnt = 0;
                    mode = jtok_pkg::MODE_STR;
                end
                return jtok_pkg::ST_OK;
            end
            jtok_pkg::MODE_PRIM:
            begin
                if ((c == jtok_pkg::CH_COLON && !strict) || is_ws(c) || c == jtok_pkg::CH_COMMA
                    || c == jtok_pkg::CH_RBRACK || c == jtok_pkg::CH_RBRACE)
                begin
                    r = close_prim(pos);
                    if (r != jtok_pkg::ST_OK)
                        return r;
                    return main_byte(c, pos);
                end
                if (c < jtok_pkg::CH_PRINT_LO || c >= jtok_pkg::CH_PRINT_HI)
                    return jtok_pkg::ST_INVALID;
                return jtok_pkg::ST_OK;
            end
            default:
                return main_byte(c, pos);
        endcase
    endfunction

    function void note_cmd(jtok_pkg::action_t a, logic [7:0] c, logic [7:0] idx);
        tok_rsp_t          x;
        jtok_pkg::status_t r;
        x.kind = '0;
        x.start = '0;
        x.finish = '0;
        x.children = '0;
        case (a)
            jtok_pkg::ACT_TEXT:
            begin
                if (err == jtok_pkg::ST_OK && !stopped)
                begin
                    if (mode == jtok_pkg::MODE_ESC && c == jtok_pkg::CH_NUL)
                        err = jtok_pkg::ST_INVALID;
                    else if (c == jtok_pkg::CH_NUL)
                        stopped = 1;
                    else if (ofs < jtok_pkg::MAX_TEXT)
                    begin
                        r = text_byte(c, ofs);
                        if (r != jtok_pkg::ST_OK)
                            err = r;
                        ofs++;
                    end
                end
                x.status = err;
            end
            jtok_pkg::ACT_FINISH:
            begin
                if (err == jtok_pkg::ST_OK && mode == jtok_pkg::MODE_PRIM && !strict)
                begin
                    r = close_prim(ofs);
                    if (r != jtok_pkg::ST_OK)
                        err = r;
                end
                x.status = err;
                if (x.status == jtok_pkg::ST_OK && mode != jtok_pkg::MODE_MAIN)
                    x.status = jtok_pkg::ST_PARTIAL;
                if (x.status == jtok_pkg::ST_OK)
                    for (int i = 0; i < used; i++)
                        if (ends[i] == -1)
                            x.status = jtok_pkg::ST_PARTIAL;
            end
            jtok_pkg::ACT_READ:
            begin
                if (idx < used)
                begin
                    x.kind = kinds[idx];
                    x.start = starts[idx][15:0];
                    x.finish = ends[idx][17:0];
                    x.children = kids[idx][7:0];
                end
                x.status = err;
            end
            default:
            begin
                restart();
                x.status = jtok_pkg::ST_OK;
            end
        endcase
        x.count = used[8:0];
        pending_q.push_back(x);
    endfunction

    function void check_rsp(tok_rsp_t got);
        tok_rsp_t x;
        if (pending_q.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected response: status %0d count %0d", got.status, got.count);
            return;
        end
        x = pending_q.pop_front();
        if (got.status !== x.status || got.count !== x.count || got.kind !== x.kind
            || got.start !== x.start || got.finish !== x.finish
            || got.children !== x.children)
        begin
            errors++;
            if (errors <= 10)
                $display({"mismatch: exp st %0d cnt %0d k %0d s %0d e %h ch %0d,",
                          " got st %0d cnt %0d k %0d s %0d e %h ch %0d"},
                         x.status, x.count, x.kind, x.start, x.finish, x.children,
                         got.status, got.count, got.kind, got.start, got.finish,
                         got.children);
        end
    endfunction
endclass

module tb_json_tokenizer;
    logic clk = 0;
    logic rst_n = 0;
    logic cfg_write = 0;
    logic cfg_data = 0;

    jtok_cmd_if cmd ();
    jtok_rsp_if rsp ();

    json_tokenizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .cmd       (cmd.sink),
        .rsp       (rsp.source)
    );

    always #2 clk = ~clk;

    tok_scoreboard token_table = new();
    logic [7:0]    text_q[$];
    bit            calm = 0;
    int            sent = 0;
    int            quiet_cycles = 0;
    int            rsp_hold = 0;
    bit            rsp_hold_level = 1;

    initial
    begin
        cmd.valid = 0;
        cmd.action = jtok_pkg::ACT_TEXT;
        cmd.data_byte = 0;
        cmd.token_index = 0;
        rsp.ready = 0;
    end

    // transfer monitor
    always @(posedge clk)
    begin
        tok_rsp_t got;
        if (cmd.valid && cmd.ready)
            token_table.note_cmd(jtok_pkg::action_t'(cmd.action), cmd.data_byte,
                                 cmd.token_index);
        if (rsp.valid && rsp.ready)
        begin
            got.status = jtok_pkg::status_t'(rsp.status);
            got.count = rsp.token_count;
            got.kind = rsp.token_kind;
            got.start = rsp.token_start;
            got.finish = rsp.token_end;
            got.children = rsp.token_children;
            token_table.check_rsp(got);
        end
        if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= 20000)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // response stalls in bursts
    always @(negedge clk)
    begin
        if (!rst_n || calm)
            rsp.ready <= 1;
        else
        begin
            if (rsp_hold == 0)
            begin
                rsp_hold_level = ($urandom_range(0, 2) != 0);
                rsp_hold = rsp_hold_level ? $urandom_range(1, 16) : $urandom_range(1, 8);
            end
            rsp_hold--;
            rsp.ready <= rsp_hold_level;
        end
    end

    task automatic send(jtok_pkg::action_t a, logic [7:0] c, logic [7:0] idx);
        int gap;
        gap = (!calm && $urandom_range(0, 9) == 0) ? $urandom_range(1, 8) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            cmd.valid = 0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd.valid = 1;
        cmd.action = a;
        cmd.data_byte = c;
        cmd.token_index = idx;
        do @(posedge clk); while (!(cmd.valid && cmd.ready));
        sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        cmd.valid = 0;
        while (token_table.pending_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_strict(bit v);
        drain();
        cfg_write = 1;
        cfg_data = v;
        token_table.strict = v;
        @(negedge clk);
        cfg_write = 0;
    endtask

    task automatic push_str(string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    task automatic gen_value(int depth);
        int n;
        case ($urandom_range(0, (depth > 2) ? 2 : 4))
            0:
            begin
                if ($urandom_range(0, 1) != 0)
                    push_str("true");
                else
                    push_str("-12.5e3");
            end
            1:
            begin
                if ($urandom_range(0, 1) != 0)
                    push_str("null");
                else
                    push_str("0");
            end
            2:
            begin
                text_q.push_back(jtok_pkg::CH_QUOTE);
                n = $urandom_range(0, 4);
                repeat (n)
                    case ($urandom_range(0, 5))
                        0: push_str("\\n");
                        1: push_str("\\u0aF9");
                        2: push_str("\\\"");
                        default: text_q.push_back(8'($urandom_range(93, 126)));
                    endcase
                text_q.push_back(jtok_pkg::CH_QUOTE);
            end
            3:
            begin
                text_q.push_back(jtok_pkg::CH_LBRACK);
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++)
                begin
                    if (i > 0)
                    begin
                        if ($urandom_range(0, 1) != 0)
                            push_str(",");
                        else
                            push_str(", ");
                    end
                    gen_value(depth + 1);
                end
                text_q.push_back(jtok_pkg::CH_RBRACK);
            end
            default:
            begin
                text_q.push_back(jtok_pkg::CH_LBRACE);
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++)
                begin
                    if (i > 0)
                        text_q.push_back(jtok_pkg::CH_COMMA);
                    push_str("\"k\":");
                    gen_value(depth + 1);
                end
                text_q.push_back(jtok_pkg::CH_RBRACE);
            end
        endcase
    endtask

    task automatic run_text(bit noisy);
        int pos;
        text_q.delete();
        gen_value(0);
        if (noisy)
            repeat ($urandom_range(1, 3))
            begin
                pos = $urandom_range(0, text_q.size());
                case ($urandom_range(0, 3))
                    0: text_q.insert(pos, 8'($urandom_range(0, 255)));
                    1: text_q.insert(pos, jtok_pkg::CH_BSLASH);
                    2: text_q.insert(pos, ($urandom_range(0, 1) != 0) ? jtok_pkg::CH_RBRACE
                                                                       : jtok_pkg::CH_RBRACK);
                    default: text_q.insert(pos, 8'($urandom_range(128, 255)));
                endcase
            end
        if ($urandom_range(0, 3) == 0)
            text_q.push_back(jtok_pkg::CH_NUL);
        foreach (text_q[i])
            send(jtok_pkg::ACT_TEXT, text_q[i], 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 4) == 0)
            send(jtok_pkg::ACT_TEXT, 8'($urandom_range(1, 255)), 8'd0);
        send(jtok_pkg::ACT_FINISH, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        repeat ($urandom_range(1, 4))
            send(jtok_pkg::ACT_READ, 8'($urandom_range(0, 255)),
                 ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, token_table.used + 1)));
        send(jtok_pkg::ACT_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    task automatic run_directed(string s);
        push_str(s);
        foreach (text_q[i])
            send(jtok_pkg::ACT_TEXT, text_q[i], 8'hFF);
        text_q.delete();
        send(jtok_pkg::ACT_FINISH, 8'd0, 8'd0);
        send(jtok_pkg::ACT_READ, 8'd0, 8'd2);
        send(jtok_pkg::ACT_READ, 8'hFF, 8'hFF);
        send(jtok_pkg::ACT_CLEAR, 8'd0, 8'd0);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        set_strict(0);
        run_directed("{\"a\":[1,\"\\u00Ff\",tru]}");
        run_directed("[\"x\\");
        send(jtok_pkg::ACT_TEXT, jtok_pkg::CH_NUL, 8'd0);
        send(jtok_pkg::ACT_FINISH, 8'd0, 8'd0);
        send(jtok_pkg::ACT_CLEAR, 8'd0, 8'd0);
        // fill the table past its end
        send(jtok_pkg::ACT_TEXT, jtok_pkg::CH_LBRACK, 8'd0);
        repeat (jtok_pkg::MAX_TOKENS + 1)
        begin
            send(jtok_pkg::ACT_TEXT, 8'h31, 8'd0);
            send(jtok_pkg::ACT_TEXT, jtok_pkg::CH_SPACE, 8'd0);
        end
        send(jtok_pkg::ACT_FINISH, 8'd0, 8'd0);
        send(jtok_pkg::ACT_READ, 8'd0, 8'hFF);
        send(jtok_pkg::ACT_CLEAR, 8'd0, 8'd0);
        set_strict(1);
        run_directed("{\"a\":1,\"b\":[2]}");
        for (int ph = 0; ph < 6; ph++)
        begin
            set_strict(ph[0]);
            while (sent < 600 + ph * 50)
                run_text($urandom_range(0, 3) == 0);
        end
        calm = 1;
        set_strict(1);
        while (sent < 950)
            run_text($urandom_range(0, 3) == 0);
        drain();
        repeat (600) @(posedge clk);
        if (token_table.errors == 0 && token_table.pending_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
